// ----- rtl/ibfcs_pkg.sv -----
// Shared types, constants and scaling functions for the IMU burst frame checker and scaler.
package ibfcs_pkg;

	localparam int WORD_W      = 16;
	localparam int IDX_W       = 5;
	localparam int DEST_W      = 3;
	localparam int NUM_SCALED  = 7;
	localparam int RAW_W       = 33;
	localparam int Q_W         = 28;
	localparam int RES_W       = 26;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 36;

	localparam int TEMP_W  = 25;
	localparam int GYRO_W  = 27;
	localparam int ACCEL_W = 24;

	// burst word positions
	localparam logic [IDX_W-1:0] BURST_WORDS   = 5'd18;
	localparam logic [IDX_W-1:0] LAST_INDEX    = 5'd17;
	localparam logic [IDX_W-1:0] WORD_FLAGS    = 5'd0;
	localparam logic [IDX_W-1:0] WORD_TEMP_HI  = 5'd1;
	localparam logic [IDX_W-1:0] WORD_TEMP_LO  = 5'd2;
	localparam logic [IDX_W-1:0] WORD_GYRO_LO  = 5'd8;
	localparam logic [IDX_W-1:0] WORD_ACCEL_HI = 5'd13;
	localparam logic [IDX_W-1:0] WORD_ACCEL_LO = 5'd14;
	localparam logic [IDX_W-1:0] WORD_GPIO     = 5'd15;
	localparam logic [IDX_W-1:0] WORD_COUNT    = 5'd16;

	// slots of the scaled value store
	localparam logic [DEST_W-1:0] DEST_TEMP    = 3'd0;
	localparam logic [DEST_W-1:0] DEST_GYRO_X  = 3'd1;
	localparam logic [DEST_W-1:0] DEST_GYRO_Y  = 3'd2;
	localparam logic [DEST_W-1:0] DEST_GYRO_Z  = 3'd3;
	localparam logic [DEST_W-1:0] DEST_ACCEL_X = 3'd4;
	localparam logic [DEST_W-1:0] DEST_ACCEL_Y = 3'd5;
	localparam logic [DEST_W-1:0] DEST_ACCEL_Z = 3'd6;

	// y = off + round(num * v / den), ties up; temperature uses v = zero point - raw
	localparam logic signed [RAW_W-1:0] TEMP_RAW_ZERO = 33'sd172621824;
	localparam longint TEMP_NUM    = 75836;
	localparam longint TEMP_DEN    = 20000000;
	localparam longint TEMP_OFFSET = 1638400;
	localparam longint GYRO_NUM    = 4;
	localparam longint GYRO_DEN    = 250;
	localparam longint ACCEL_NUM   = 98;
	localparam longint ACCEL_DEN   = 50000;

	localparam longint TEMP_RECIP_L  = (TEMP_NUM << RECIP_SHIFT) / TEMP_DEN;
	localparam longint GYRO_RECIP_L  = (GYRO_NUM << RECIP_SHIFT) / GYRO_DEN;
	localparam longint ACCEL_RECIP_L = (ACCEL_NUM << RECIP_SHIFT) / ACCEL_DEN;

	typedef enum logic [1:0] {
		KIND_TEMP  = 2'd0,
		KIND_GYRO  = 2'd1,
		KIND_ACCEL = 2'd2
	} kind_t;

	typedef struct packed {
		logic                     valid;
		kind_t                    kind;
		logic [DEST_W-1:0]        dest;
		logic signed [RAW_W-1:0]  value;
	} scale_req_t;

	typedef struct packed {
		logic                     valid;
		logic [DEST_W-1:0]        dest;
		logic signed [Q_W-1:0]    value;
	} scale_res_t;

	function automatic logic [RECIP_W-1:0] kind_recip(input kind_t kind);
		logic [RECIP_W-1:0] r;
		case (kind)
			KIND_TEMP:  r = RECIP_W'(TEMP_RECIP_L);
			KIND_GYRO:  r = RECIP_W'(GYRO_RECIP_L);
			KIND_ACCEL: r = RECIP_W'(ACCEL_RECIP_L);
			default:    r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [RES_W-1:0] kind_num(input kind_t kind);
		logic [RES_W-1:0] r;
		case (kind)
			KIND_TEMP:  r = RES_W'(TEMP_NUM);
			KIND_GYRO:  r = RES_W'(GYRO_NUM);
			KIND_ACCEL: r = RES_W'(ACCEL_NUM);
			default:    r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [RES_W-1:0] kind_den(input kind_t kind);
		logic [RES_W-1:0] r;
		case (kind)
			KIND_TEMP:  r = RES_W'(TEMP_DEN);
			KIND_GYRO:  r = RES_W'(GYRO_DEN);
			KIND_ACCEL: r = RES_W'(ACCEL_DEN);
			default:    r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/ibfcs_scaler.sv -----
// Pipelined constant scaler: reciprocal multiply, residual, one-step rounding correction.
module ibfcs_scaler (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ibfcs_pkg::scale_req_t  req,
	output ibfcs_pkg::scale_res_t  res
);

	logic signed [2*ibfcs_pkg::RAW_W-1:0] prod;
	logic signed [ibfcs_pkg::Q_W-1:0]     q0;
	logic [ibfcs_pkg::RES_W-1:0]          av;

	logic                                 valid_s1;
	ibfcs_pkg::kind_t                     kind_s1;
	logic [ibfcs_pkg::DEST_W-1:0]         dest_s1;
	logic signed [ibfcs_pkg::Q_W-1:0]     q0_s1;
	logic [ibfcs_pkg::RES_W-1:0]          av_s1;

	logic                                 valid_s2;
	ibfcs_pkg::kind_t                     kind_s2;
	logic [ibfcs_pkg::DEST_W-1:0]         dest_s2;
	logic signed [ibfcs_pkg::Q_W-1:0]     q0_s2;
	logic [ibfcs_pkg::RES_W-1:0]          rem_s2;

	logic [ibfcs_pkg::RES_W-1:0]          den_s1;
	logic [ibfcs_pkg::RES_W-1:0]          den_s2;
	logic [ibfcs_pkg::Q_W-1:0]            round_up;
	logic [ibfcs_pkg::Q_W-1:0]            offset;

	// stage 1: truncated quotient estimate, low bits of num * v
	assign prod = $signed(req.value) * $signed({1'b0, ibfcs_pkg::kind_recip(req.kind)});
	assign q0   = prod[ibfcs_pkg::RECIP_SHIFT+ibfcs_pkg::Q_W-1:ibfcs_pkg::RECIP_SHIFT];
	assign av   = ibfcs_pkg::RES_W'(req.value[ibfcs_pkg::RES_W-1:0] *
		ibfcs_pkg::kind_num(req.kind));

	// stage 2: residual num*v + den/2 - q0*den, known to lie in [0, 2*den)
	assign den_s1 = ibfcs_pkg::kind_den(kind_s1);

	// stage 3: add the correction step and the temperature offset
	assign den_s2   = ibfcs_pkg::kind_den(kind_s2);
	assign round_up = ibfcs_pkg::Q_W'(rem_s2 >= den_s2);
	assign offset   = (kind_s2 == ibfcs_pkg::KIND_TEMP) ?
		ibfcs_pkg::Q_W'(ibfcs_pkg::TEMP_OFFSET) : '0;

	assign res.valid = valid_s2;
	assign res.dest  = dest_s2;
	assign res.value = $signed(ibfcs_pkg::Q_W'(q0_s2) + round_up + offset);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= req.kind;
		dest_s1 <= req.dest;
		q0_s1   <= q0;
		av_s1   <= av;

		kind_s2 <= kind_s1;
		dest_s2 <= dest_s1;
		q0_s2   <= q0_s1;
		rem_s2  <= ibfcs_pkg::RES_W'(av_s1 + (den_s1 >> 1) -
			ibfcs_pkg::RES_W'(q0_s1[ibfcs_pkg::RES_W-1:0] * den_s1));
	end

	// residual bound: at most one correction step is ever needed
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (rem_s2 < (den_s2 << 1)))
		else $error("scaler residual out of range");

	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |=> ##1 valid_s2)
		else $error("scaler request lost in pipeline");

	a_dest_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (dest_s2 <= ibfcs_pkg::DEST_ACCEL_Z))
		else $error("scaler destination out of range");

endmodule

// ----- rtl/imu_burst_frame_checker_scaler_core.sv -----
// Top level: IMU burst word sequencing, checksum and scaled result output.
// Throughput: one burst word per cycle while in_ready is high; a word is taken while a result waits in the output.
// The checksum beat parks the frame in s1; the result moves into the output registers once the output is free.
// Each pair's low word feeds a three-stage scaler (one 33x32 reciprocal multiply).
// in_ready drops only while a finished frame is held behind an unaccepted result.
// Reset clears word index, running sum, scaler request and valid flags; other payload is not reset.
module imu_burst_frame_checker_scaler_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               start_frame,
	input  logic [ibfcs_pkg::WORD_W-1:0]       rx_word,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               checksum_ok,
	output logic [ibfcs_pkg::WORD_W-1:0]       status_flags,
	output logic signed [ibfcs_pkg::TEMP_W-1:0]  temperature_q16,
	output logic signed [ibfcs_pkg::GYRO_W-1:0]  gyro_x_q16,
	output logic signed [ibfcs_pkg::GYRO_W-1:0]  gyro_y_q16,
	output logic signed [ibfcs_pkg::GYRO_W-1:0]  gyro_z_q16,
	output logic signed [ibfcs_pkg::ACCEL_W-1:0] accel_x_q16,
	output logic signed [ibfcs_pkg::ACCEL_W-1:0] accel_y_q16,
	output logic signed [ibfcs_pkg::ACCEL_W-1:0] accel_z_q16,
	output logic [ibfcs_pkg::WORD_W-1:0]       gpio_word,
	output logic [ibfcs_pkg::WORD_W-1:0]       sample_count
);

	logic [ibfcs_pkg::IDX_W-1:0]   word_index_q;
	logic [ibfcs_pkg::WORD_W-1:0]  sum_q;
	logic [ibfcs_pkg::IDX_W-1:0]   idx_eff;
	logic [ibfcs_pkg::WORD_W-1:0]  sum_eff;
	logic                          in_fire;
	logic                          is_last;
	logic                          is_hi;
	logic                          is_lo;
	logic [2*ibfcs_pkg::WORD_W-1:0] raw;

	logic [ibfcs_pkg::WORD_W-1:0]  hi_q;
	logic [ibfcs_pkg::WORD_W-1:0]  flags_q;
	logic [ibfcs_pkg::WORD_W-1:0]  gpio_q;
	logic [ibfcs_pkg::WORD_W-1:0]  count_q;

	ibfcs_pkg::scale_req_t         req_q;
	ibfcs_pkg::scale_req_t         req_d;
	ibfcs_pkg::scale_res_t         scale_res;
	logic signed [ibfcs_pkg::Q_W-1:0] scaled_q [ibfcs_pkg::NUM_SCALED];

	logic                          last_valid_s1;
	logic                          checksum_ok_s1;
	logic                          s1_move;

	logic                          out_valid_q;
	logic                          ok_q;
	logic [ibfcs_pkg::WORD_W-1:0]  out_flags_q;
	logic [ibfcs_pkg::WORD_W-1:0]  out_gpio_q;
	logic [ibfcs_pkg::WORD_W-1:0]  out_count_q;
	logic signed [ibfcs_pkg::TEMP_W-1:0]  out_temp_q;
	logic signed [ibfcs_pkg::GYRO_W-1:0]  out_gx_q;
	logic signed [ibfcs_pkg::GYRO_W-1:0]  out_gy_q;
	logic signed [ibfcs_pkg::GYRO_W-1:0]  out_gz_q;
	logic signed [ibfcs_pkg::ACCEL_W-1:0] out_ax_q;
	logic signed [ibfcs_pkg::ACCEL_W-1:0] out_ay_q;
	logic signed [ibfcs_pkg::ACCEL_W-1:0] out_az_q;

	// the frame held in s1 reads stores that new words would overwrite
	assign s1_move  = last_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !last_valid_s1 || !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign idx_eff = (start_frame || (word_index_q >= ibfcs_pkg::BURST_WORDS)) ?
		'0 : word_index_q;
	assign sum_eff = start_frame ? '0 : sum_q;
	assign is_last = (idx_eff == ibfcs_pkg::LAST_INDEX);
	assign is_hi   = idx_eff[0] &&
		(idx_eff inside {[ibfcs_pkg::WORD_TEMP_HI:ibfcs_pkg::WORD_ACCEL_HI]});
	assign is_lo   = !idx_eff[0] &&
		(idx_eff inside {[ibfcs_pkg::WORD_TEMP_LO:ibfcs_pkg::WORD_ACCEL_LO]});
	assign raw     = {hi_q, rx_word};

	always_comb begin
		req_d.valid = in_fire && is_lo;
		req_d.dest  = ibfcs_pkg::DEST_W'(idx_eff[ibfcs_pkg::IDX_W-1:1] - 4'd1);
		if (idx_eff == ibfcs_pkg::WORD_TEMP_LO) begin
			req_d.kind  = ibfcs_pkg::KIND_TEMP;
			req_d.value = ibfcs_pkg::TEMP_RAW_ZERO - $signed({raw[2*ibfcs_pkg::WORD_W-1], raw});
		end else if (idx_eff <= ibfcs_pkg::WORD_GYRO_LO) begin
			req_d.kind  = ibfcs_pkg::KIND_GYRO;
			req_d.value = $signed({raw[2*ibfcs_pkg::WORD_W-1], raw});
		end else begin
			req_d.kind  = ibfcs_pkg::KIND_ACCEL;
			req_d.value = $signed({raw[2*ibfcs_pkg::WORD_W-1], raw});
		end
	end

	ibfcs_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.res    (scale_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q  <= '0;
			sum_q         <= '0;
			req_q         <= '0;
			last_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			req_q <= req_d;
			if (in_fire) begin
				if (is_last) begin
					word_index_q <= '0;
					sum_q        <= '0;
				end else begin
					word_index_q <= idx_eff + 5'd1;
					sum_q        <= sum_eff + rx_word;
				end
			end
			if (in_fire && is_last) begin
				last_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				last_valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (idx_eff == ibfcs_pkg::WORD_FLAGS) begin
				flags_q <= rx_word;
			end
			if (idx_eff == ibfcs_pkg::WORD_GPIO) begin
				gpio_q <= rx_word;
			end
			if (idx_eff == ibfcs_pkg::WORD_COUNT) begin
				count_q <= rx_word;
			end
			if (is_hi) begin
				hi_q <= rx_word;
			end
			if (is_last) begin
				checksum_ok_s1 <= (sum_eff == rx_word);
			end
		end
		if (scale_res.valid) begin
			scaled_q[scale_res.dest] <= scale_res.value;
		end
		if (s1_move) begin
			ok_q        <= checksum_ok_s1;
			out_flags_q <= flags_q;
			out_gpio_q  <= gpio_q;
			out_count_q <= count_q;
			out_temp_q  <= scaled_q[ibfcs_pkg::DEST_TEMP][ibfcs_pkg::TEMP_W-1:0];
			out_gx_q    <= scaled_q[ibfcs_pkg::DEST_GYRO_X][ibfcs_pkg::GYRO_W-1:0];
			out_gy_q    <= scaled_q[ibfcs_pkg::DEST_GYRO_Y][ibfcs_pkg::GYRO_W-1:0];
			out_gz_q    <= scaled_q[ibfcs_pkg::DEST_GYRO_Z][ibfcs_pkg::GYRO_W-1:0];
			out_ax_q    <= scaled_q[ibfcs_pkg::DEST_ACCEL_X][ibfcs_pkg::ACCEL_W-1:0];
			out_ay_q    <= scaled_q[ibfcs_pkg::DEST_ACCEL_Y][ibfcs_pkg::ACCEL_W-1:0];
			out_az_q    <= scaled_q[ibfcs_pkg::DEST_ACCEL_Z][ibfcs_pkg::ACCEL_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign checksum_ok     = ok_q;
	assign status_flags    = out_flags_q;
	assign temperature_q16 = out_temp_q;
	assign gyro_x_q16      = out_gx_q;
	assign gyro_y_q16      = out_gy_q;
	assign gyro_z_q16      = out_gz_q;
	assign accel_x_q16     = out_ax_q;
	assign accel_y_q16     = out_ay_q;
	assign accel_z_q16     = out_az_q;
	assign gpio_word       = out_gpio_q;
	assign sample_count    = out_count_q;

	// a checksum beat restarts the index and the sum and parks the frame in s1
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_last) |=> (last_valid_s1 && word_index_q == '0 && sum_q == '0))
		else $error("checksum beat did not close the frame");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		word_index_q <= ibfcs_pkg::LAST_INDEX)
		else $error("word index beyond burst length");

	// scaled values of a frame land before its checksum beat reaches s1
	a_scale_before_last: assert property (@(posedge clk) disable iff (!arst_n)
		scale_res.valid |-> !last_valid_s1)
		else $error("scaler write overlaps a held frame");

	a_hold_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(last_valid_s1 && !s1_move) |-> !in_ready)
		else $error("input taken while a frame is held");

endmodule
